[src/smt_pkg.sv]
// ----------------------------------------------------------------------------
// smt_pkg: shared definitions of the set membership table
// Capacity, derived widths, request and status codes, and the structs
// that pass between the control logic and the row of cells.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 27;

  // Largest value of eight decimal digits.
  localparam logic [VAL_W-1:0] MAX_VALUE = VAL_W'(99999999);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Broadcast from the control logic to every cell.
  typedef struct packed {
    logic [VAL_W-1:0] key;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] last;
    logic             ins_en;
    logic             del_en;
  } cell_ctl_t;

  // Handed from each cell to its right-hand neighbor.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] pos;
    logic [VAL_W-1:0] last;
  } chain_t;

endpackage

[src/smt_cell.sv]
// ----------------------------------------------------------------------------
// smt_cell: one slot of the set membership table
// Holds one entry, compares it with the request key, and passes the first
// match and the value of the last occupied slot on to its neighbor.
// ----------------------------------------------------------------------------
module smt_cell
  import smt_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctl_t        ctl,
  input  chain_t           chain_in,
  output chain_t           chain_out
);

  logic [VAL_W-1:0] entry_r;
  logic [VAL_W-1:0] entry_nxt;
  logic [CNT_W-1:0] idx_ext;
  logic             occupied;
  logic             match;
  logic             is_last;
  logic             is_free;

  assign idx_ext  = CNT_W'(idx);
  assign occupied = idx_ext < ctl.count;
  assign match    = occupied && (entry_r == ctl.key);
  assign is_last  = (idx_ext + CNT_W'(1)) == ctl.count;
  assign is_free  = idx_ext == ctl.count;

  always_comb begin
    chain_out.hit  = chain_in.hit | match;
    chain_out.pos  = chain_in.hit ? chain_in.pos : (match ? idx : '0);
    chain_out.last = is_last ? entry_r : chain_in.last;
  end

  // Insert fills the first free slot; delete pulls the last entry into the hit slot.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_en && is_free) begin
      entry_nxt = ctl.key;
    end else if (ctl.del_en && match) begin
      entry_nxt = ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[src/small_set_membership_table_top.sv]
// ----------------------------------------------------------------------------
// small_set_membership_table_top: bounded set of distinct values
// Insert, delete (swap last into hole) and query over a row of cells.
//
//   channel | dir | tdata (low bit up)                       | tuser
//   in_     | in  | element_value[26:0], zero pad to 32      | command[1:0]
//   out_    | out | found, position[3:0], element_count[4:0], | none
//           |     | status[1:0], zero pad to 16              |
//
// An item is accepted into registers, then evaluated across all cells at
// once; no new item is taken until its result is in the output register.
// The result waits there; a stalled output holds the pending item in evaluation.
// Reset clears the count and handshake state; entries need no reset.
// ----------------------------------------------------------------------------
module small_set_membership_table_top
  import smt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // element_value[26:0]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // found, position[3:0], element_count[4:0], status[1:0]
);

  logic             busy_r;
  logic [1:0]       cmd_r;
  logic [VAL_W-1:0] key_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic             found_r;
  logic [3:0]       pos_r;
  logic [4:0]       cnt_out_r;
  status_t          status_r, status_nxt;

  cell_ctl_t        ctl;
  chain_t           chain [CAPACITY+1];
  logic             room;
  logic             fire;
  logic             hit;
  logic [IDX_W+3:0] pos_ext;
  logic [CNT_W+4:0] cnt_ext;

  assign room      = !out_valid_r || out_tready;
  assign fire      = busy_r && room;
  assign in_tready = !busy_r;
  assign hit       = chain[CAPACITY].hit;

  assign chain[0] = '{hit: 1'b0, pos: '0, last: '0};

  always_comb begin
    ctl.key    = key_r;
    ctl.count  = count_r;
    ctl.last   = chain[CAPACITY].last;
    ctl.ins_en = fire && (cmd_r == CMD_INSERT) && !hit && (key_r <= MAX_VALUE)
                 && (count_r < CNT_W'(CAPACITY));
    ctl.del_en = fire && (cmd_r == CMD_DELETE) && hit;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    smt_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .ctl       (ctl),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.del_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    case (cmd_r)
      CMD_INSERT: begin
        if (hit) begin
          status_nxt = ST_PRESENT;
        end else if (key_r > MAX_VALUE) begin
          status_nxt = ST_ABSENT;
        end else if (count_r >= CNT_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_DONE;
        end
      end
      default: begin
        status_nxt = hit ? ST_DONE : ST_ABSENT;
      end
    endcase
  end

  assign pos_ext = {4'b0, chain[CAPACITY].pos};
  assign cnt_ext = {5'b0, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        busy_r <= 1'b1;
      end else if (fire) begin
        busy_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= in_tuser;
      key_r <= in_tdata[VAL_W-1:0];
    end
    if (fire) begin
      found_r   <= hit;
      pos_r     <= pos_ext[3:0];
      cnt_out_r <= cnt_ext[4:0];
      status_r  <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, status_r, cnt_out_r, pos_r, found_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_ins_del_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.ins_en && ctl.del_en))
    else $error("insert and delete enabled together");

  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !room |=> busy_r)
    else $error("pending item dropped while output stalled");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the count");

endmodule
